FILE: rtl/bakery_ticket_lock_arbiter_core_macros.svh
// Assertion macros for the bakery ticket lock arbiter checker.
// Expects signals clk and rst in the scope of each use.
`ifndef BAKERY_TICKET_LOCK_ARBITER_CORE_MACROS_SVH
`define BAKERY_TICKET_LOCK_ARBITER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BTLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/btla_pkg.sv
// Shared types and codes for the bakery ticket lock arbiter.
// No dependencies; used by the cell, the top level and the checker.
package btla_pkg;

  localparam int ID_W = 4;

  localparam logic OP_LOCK    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] requester;
  } cmd_t;

  typedef struct packed {
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
    logic            error;
  } result_t;

  // write strobe broadcast to the cell row
  typedef struct packed {
    logic            en;
    logic            flag;
    logic            load_ticket;
    logic [ID_W-1:0] id;
  } cell_wr_t;

endpackage

FILE: rtl/bakery_ticket_lock_arbiter_core.sv
// Bakery ticket lock arbiter: a row of requester cells and the command sequencer.
// Depends on btla_pkg and btla_cell.
//
// Usage:
//   A command word (op, requester) is taken at a rising edge with start high
//   and busy low. op lock asks for the lock, op release gives it back.
//   Each command yields exactly one result word on result, shown for one
//   cycle with done high; the receiver cannot stall it and need not.
// Timing:
//   A scan wave walks the cell row one cell per cycle, gathering the largest
//   ticket, the smallest flagged (ticket, id) apart from the requester, and
//   that requester's own slot. A command runs through a scan state for the
//   wave and a finish state for the decision; done is registered as the
//   finish state ends and is high in a cycle where busy is
//   already low, so the next command can be taken alongside the result.
// Reset:
//   rst clears every flag and ticket, frees the lock and returns to idle;
//   a command in flight is dropped without a result word.
module bakery_ticket_lock_arbiter_core #(
  parameter int REQUESTERS  = 16,
  parameter int TICKET_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  btla_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done,
  output btla_pkg::result_t  result
);

  localparam int CNT_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam logic [CNT_W-1:0]       CNT_LAST   = CNT_W'(REQUESTERS - 1);
  localparam logic [TICKET_BITS-1:0] TICKET_TOP = {TICKET_BITS{1'b1}};

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                   state;
  logic [CNT_W-1:0]             cnt;
  btla_pkg::cmd_t               cmd_q;
  logic                         holder_valid;
  logic [btla_pkg::ID_W-1:0]    holder_id;

  logic [TICKET_BITS-1:0]       max_chain        [REQUESTERS+1];
  logic                         min_found_chain  [REQUESTERS+1];
  logic [TICKET_BITS-1:0]       min_ticket_chain [REQUESTERS+1];
  logic [btla_pkg::ID_W-1:0]    min_id_chain     [REQUESTERS+1];
  logic                         hit_flag_chain   [REQUESTERS+1];
  logic [TICKET_BITS-1:0]       hit_ticket_chain [REQUESTERS+1];

  btla_pkg::cell_wr_t           wr;
  logic [TICKET_BITS-1:0]       new_ticket;
  logic                         id_ok;
  logic                         is_lock;
  logic                         lock_ok;
  logic                         release_ok;
  logic                         err;
  logic                         holder_after;
  logic                         cand_en;
  logic [TICKET_BITS-1:0]       cand_ticket;
  logic                         cand_wins;
  logic                         grant;
  logic [btla_pkg::ID_W-1:0]    grant_id;
  logic                         base_found;
  logic [TICKET_BITS-1:0]       base_ticket;
  logic [btla_pkg::ID_W-1:0]    base_id;
  logic                         hit_flag;
  logic [TICKET_BITS-1:0]       hit_ticket;
  logic [TICKET_BITS-1:0]       max_ticket;

  assign busy = (state != S_IDLE);

  // wave seed
  assign max_chain[0]        = '0;
  assign min_found_chain[0]  = 1'b0;
  assign min_ticket_chain[0] = '0;
  assign min_id_chain[0]     = '0;
  assign hit_flag_chain[0]   = 1'b0;
  assign hit_ticket_chain[0] = '0;

  for (genvar i = 0; i < REQUESTERS; i++) begin : g_cell
    btla_cell #(
      .INDEX       (i),
      .TICKET_BITS (TICKET_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .scan_id        (cmd_q.requester),
      .wr             (wr),
      .wr_ticket      (new_ticket),
      .max_in         (max_chain[i]),
      .min_found_in   (min_found_chain[i]),
      .min_ticket_in  (min_ticket_chain[i]),
      .min_id_in      (min_id_chain[i]),
      .hit_flag_in    (hit_flag_chain[i]),
      .hit_ticket_in  (hit_ticket_chain[i]),
      .max_out        (max_chain[i+1]),
      .min_found_out  (min_found_chain[i+1]),
      .min_ticket_out (min_ticket_chain[i+1]),
      .min_id_out     (min_id_chain[i+1]),
      .hit_flag_out   (hit_flag_chain[i+1]),
      .hit_ticket_out (hit_ticket_chain[i+1])
    );
  end

  assign max_ticket  = max_chain[REQUESTERS];
  assign base_found  = min_found_chain[REQUESTERS];
  assign base_ticket = min_ticket_chain[REQUESTERS];
  assign base_id     = min_id_chain[REQUESTERS];
  assign hit_flag    = hit_flag_chain[REQUESTERS];
  assign hit_ticket  = hit_ticket_chain[REQUESTERS];

  // decision, valid in the finish cycle once the wave has left the last cell
  always_comb begin
    new_ticket   = (max_ticket == TICKET_TOP) ? TICKET_TOP : max_ticket + TICKET_BITS'(1);
    id_ok        = (int'(cmd_q.requester) < REQUESTERS);
    is_lock      = (cmd_q.op == btla_pkg::OP_LOCK);
    lock_ok      = id_ok && is_lock && !hit_flag;
    release_ok   = id_ok && !is_lock && holder_valid && (holder_id == cmd_q.requester);
    err          = !(lock_ok || release_ok);
    holder_after = holder_valid && !release_ok;
    // fold the requester's own slot back into the minimum unless it just left
    cand_en      = id_ok && !release_ok && (hit_flag || is_lock);
    cand_ticket  = hit_flag ? hit_ticket : new_ticket;
    cand_wins    = cand_en && (!base_found || (cand_ticket < base_ticket) ||
                   ((cand_ticket == base_ticket) && (cmd_q.requester < base_id)));
    grant        = !holder_after && (base_found || cand_en);
    grant_id     = cand_wins ? cmd_q.requester : base_id;

    wr.en          = (state == S_FINISH) && (lock_ok || release_ok);
    wr.flag        = lock_ok;
    wr.load_ticket = lock_ok;
    wr.id          = cmd_q.requester;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      holder_valid <= 1'b0;
      holder_id    <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (grant) begin
            holder_valid <= 1'b1;
            holder_id    <= grant_id;
          end else if (release_ok) begin
            holder_valid <= 1'b0;
            holder_id    <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: hold the command word, load the result word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    if (state == S_FINISH) begin
      result.grant_valid <= grant;
      result.grant_id    <= grant ? grant_id : '0;
      result.error       <= err;
    end
  end

endmodule

FILE: rtl/btla_cell.sv
// One requester slot: waiting flag and ticket, plus one stage of the scan wave.
// Depends on btla_pkg.
module btla_cell #(
  parameter int INDEX       = 0,
  parameter int TICKET_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [btla_pkg::ID_W-1:0]     scan_id,
  input  btla_pkg::cell_wr_t            wr,
  input  logic [TICKET_BITS-1:0]        wr_ticket,
  input  logic [TICKET_BITS-1:0]        max_in,
  input  logic                          min_found_in,
  input  logic [TICKET_BITS-1:0]        min_ticket_in,
  input  logic [btla_pkg::ID_W-1:0]     min_id_in,
  input  logic                          hit_flag_in,
  input  logic [TICKET_BITS-1:0]        hit_ticket_in,
  output logic [TICKET_BITS-1:0]        max_out,
  output logic                          min_found_out,
  output logic [TICKET_BITS-1:0]        min_ticket_out,
  output logic [btla_pkg::ID_W-1:0]     min_id_out,
  output logic                          hit_flag_out,
  output logic [TICKET_BITS-1:0]        hit_ticket_out
);

  localparam logic [btla_pkg::ID_W-1:0] MY_ID = btla_pkg::ID_W'(INDEX);

  logic                   flag;
  logic [TICKET_BITS-1:0] ticket;
  logic                   scan_match;
  logic                   wr_match;
  logic                   take_min;

  assign scan_match = (int'(scan_id) == INDEX);
  assign wr_match   = wr.en && (int'(wr.id) == INDEX);
  // skip the slot under operation; the top level folds it back in
  assign take_min   = flag && !scan_match && (!min_found_in || (ticket < min_ticket_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      flag   <= 1'b0;
      ticket <= '0;
    end else if (wr_match) begin
      flag <= wr.flag;
      if (wr.load_ticket) begin
        ticket <= wr_ticket;
      end
    end
  end

  // scan wave: advance one slot per cycle
  always_ff @(posedge clk) begin
    max_out <= (ticket > max_in) ? ticket : max_in;
    if (take_min) begin
      min_found_out  <= 1'b1;
      min_ticket_out <= ticket;
      min_id_out     <= MY_ID;
    end else begin
      min_found_out  <= min_found_in;
      min_ticket_out <= min_ticket_in;
      min_id_out     <= min_id_in;
    end
    if (scan_match) begin
      hit_flag_out   <= flag;
      hit_ticket_out <= ticket;
    end else begin
      hit_flag_out   <= hit_flag_in;
      hit_ticket_out <= hit_ticket_in;
    end
  end

endmodule

FILE: rtl/btla_checker.sv
// Port-level checks for the bakery ticket lock arbiter, bound to its top level.
// Depends on btla_pkg and the assertion macro header.
`include "bakery_ticket_lock_arbiter_core_macros.svh"

module btla_checker #(
  parameter int REQUESTERS = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input btla_pkg::cmd_t    cmd,
  input logic              busy,
  input logic              done,
  input btla_pkg::result_t result
);

  logic accept;
  logic cmd_seen;

  assign accept   = start && !busy;
  assign cmd_seen = ^cmd || !(^cmd);

  `BTLA_ASSERT_NEXT(a_accept_busy, accept && cmd_seen, busy, "accept did not raise busy")
  `BTLA_ASSERT_NOW(a_done_latency, accept, ##(REQUESTERS + 2) done, "result word late or missing")
  `BTLA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `BTLA_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `BTLA_ASSERT_NOW(a_grant_id_zero, done && !result.grant_valid, result.grant_id == '0,
    "grant id set without grant")

endmodule

bind bakery_ticket_lock_arbiter_core btla_checker #(.REQUESTERS(REQUESTERS)) u_btla_checker (.*);
